// ----- hdl/chm_pkg.sv -----
`default_nettype none

package chm_pkg;

  // Datapath width of the CORDIC vector. The corrected sample is 17 bits,
  // scaled by 256, and the CORDIC gain with the diagonal adds under two bits.
  localparam int VecW = 28;

  // Width of the angle accumulator, in units of 2^-32 of a full turn.
  localparam int AngW = 32;

  // Number of entries in the arctangent table.
  localparam int AtanLen = 24;

  // round(atan(2^-i) / (2*pi) * 2^32)
  localparam logic [AngW-1:0] ATAN_TURNS [AtanLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Half a turn, the start angle after the vector is negated.
  localparam logic [AngW-1:0] HalfTurn = 32'h80000000;

  // Configuration register indexes.
  typedef enum logic {
    CFG_OFFSET_X = 1'b0,
    CFG_OFFSET_Y = 1'b1
  } chm_cfg_e;

  // Payload that travels down the CORDIC pipeline.
  typedef struct packed {
    logic                   zero;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [AngW-1:0]        z;
  } chm_vec_t;

endpackage

`default_nettype wire

// ----- hdl/chm_prep.sv -----
`default_nettype none

module chm_prep
  import chm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               accept_i,
  input  wire logic signed [15:0] raw_x_i,
  input  wire logic signed [15:0] raw_y_i,
  output logic                    valid_o,
  output chm_vec_t                vec_o
);

  logic signed [15:0] bias_x_q, bias_x_d;
  logic signed [15:0] bias_y_q, bias_y_d;
  logic               valid_q;
  chm_vec_t           vec_q, vec_d;
  logic signed [16:0] dx, dy;
  logic signed [16:0] px, py;

  always_comb begin
    bias_x_d = bias_x_q;
    bias_y_d = bias_y_q;
    if (cfg_we_i) begin
      unique case (chm_cfg_e'(cfg_idx_i))
        CFG_OFFSET_X: bias_x_d = cfg_wdata_i;
        CFG_OFFSET_Y: bias_y_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx = 17'(raw_x_i) - 17'(bias_x_q);
    dy = 17'(raw_y_i) - 17'(bias_y_q);
    // A vector in the left half plane is turned by half a turn first, so
    // the iterations only have to cover plus or minus a quarter turn.
    if (dx < 0) begin
      px = -dx;
      py = -dy;
      vec_d.z = HalfTurn;
    end else begin
      px = dx;
      py = dy;
      vec_d.z = '0;
    end
    vec_d.x    = VecW'(px) <<< 8;
    vec_d.y    = VecW'(py) <<< 8;
    vec_d.zero = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_x_q <= '0;
      bias_y_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      bias_x_q <= bias_x_d;
      bias_y_q <= bias_y_d;
      valid_q  <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

// ----- hdl/chm_cordic_stage.sv -----
`default_nettype none

module chm_cordic_stage
  import chm_pkg::*;
#(
  parameter int Idx = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire chm_vec_t vec_i,
  output logic          valid_o,
  output chm_vec_t      vec_o
);

  logic                   valid_q;
  chm_vec_t               vec_q, vec_d;
  logic signed [VecW-1:0] xs, ys;

  always_comb begin
    xs         = vec_i.x >>> Idx;
    ys         = vec_i.y >>> Idx;
    vec_d.zero = vec_i.zero;
    // Rotate toward the x axis; both updates use the incoming x and y.
    if (vec_i.y > 0) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ATAN_TURNS[Idx];
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ATAN_TURNS[Idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

// ----- hdl/chm_scale.sv -----
`default_nettype none

module chm_scale
  import chm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic            zero_i,
  input  wire logic [AngW-1:0] z_i,
  output logic                 valid_o,
  output logic [15:0]          heading_o
);

  localparam int FullTurn = 360 << ANGLE_FRAC_BITS;
  localparam int HeadW    = $clog2(FullTurn + 1);
  localparam int ProdW    = AngW + HeadW;
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(64'h80000000);
  localparam logic [HeadW-1:0] FullVal   = HeadW'(FullTurn);

  logic             prod_valid_q;
  logic             prod_zero_q;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [ProdW-1:0] rounded;
  logic [HeadW-1:0] head_full;
  logic [31:0]      head_wide;
  logic             out_valid_q;
  logic [15:0]      heading_q, heading_d;

  assign prod_d = ProdW'(z_i) * ProdW'(FullVal);

  always_comb begin
    rounded   = prod_q + RoundHalf;
    head_full = rounded[ProdW-1:AngW];
    // A heading that rounds up to a whole turn reads as north.
    if (prod_zero_q || (head_full >= FullVal)) begin
      head_wide = '0;
    end else begin
      head_wide = 32'(head_full);
    end
    heading_d = head_wide[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q      <= prod_d;
      prod_zero_q <= zero_i;
    end
    if (prod_valid_q) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = out_valid_q;
  assign heading_o = heading_q;

endmodule

`default_nettype wire

// ----- hdl/compass_heading_from_magnetometer.sv -----
// Compass heading from one X/Y magnetometer sample with hard-iron correction.
//
// Input: a sample transfer happens at a rising edge where start is high and
// busy is low. busy stays low, so a new sample may be given in every cycle.
// Output: heading_valid_o is high for exactly one cycle with heading_o, in
// units of 2^-ANGLE_FRAC_BITS degree from 0 up to under 360 degrees. A zero
// corrected vector gives heading 0. The receiver cannot stall the block.
// Pipeline: one register for the offset subtraction and half-turn fold,
// one per CORDIC iteration (steps capped at 24), one for the multiply to
// degrees and one for rounding and the wrap at 360.
// Throughput: one sample per cycle; results come out in input order.
// Configuration: cfg_we_i writes the X offset (index 0) or the Y offset
// (index 1) from the low 16 bits of cfg_wdata_i. Write them only while no
// sample is in flight. Reset clears both offsets and empties the pipeline.
`default_nettype none

module compass_heading_from_magnetometer
  import chm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] raw_x_i,
  input  wire logic signed [15:0] raw_y_i,
  output logic                    heading_valid_o,
  output logic [15:0]             heading_o
);

  localparam int Steps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;

  logic     accept;
  logic     stage_valid [Steps+1];
  chm_vec_t stage_vec   [Steps+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  chm_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .valid_o     (stage_valid[0]),
    .vec_o       (stage_vec[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    chm_cordic_stage #(
      .Idx (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[i]),
      .vec_i   (stage_vec[i]),
      .valid_o (stage_valid[i+1]),
      .vec_o   (stage_vec[i+1])
    );
  end

  chm_scale #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid[Steps]),
    .zero_i    (stage_vec[Steps].zero),
    .z_i       (stage_vec[Steps].z),
    .valid_o   (heading_valid_o),
    .heading_o (heading_o)
  );

endmodule

`default_nettype wire

// ----- hdl/chm_checker.sv -----
`default_nettype none

module chm_checker #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        heading_valid_o,
  input wire logic [15:0] heading_o
);

  localparam int Steps    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int Latency  = Steps + 3;
  localparam int FullTurn = 360 << ANGLE_FRAC_BITS;
  localparam int Narrow   = (FullTurn <= 65536) ? 1 : 0;

  // Every accepted sample gives its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency heading_valid_o)
    else $error("accepted sample gave no result after the pipeline latency");

  // No result appears without a sample accepted the same latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_valid_o |-> $past(start && !busy, Latency))
    else $error("result without a matching sample transfer");

  // The pipeline never refuses a sample.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised on a fully pipelined block");

  // A heading that fits the output port stays below a whole turn.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_valid_o && (Narrow == 1)) |-> (32'(heading_o) < FullTurn))
    else $error("heading at or above a full turn");

endmodule

bind compass_heading_from_magnetometer chm_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
  .CORDIC_STEPS    (CORDIC_STEPS)
) u_chm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .heading_valid_o (heading_valid_o),
  .heading_o       (heading_o)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import chm_pkg::*;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] raw_x_i = '0;
  logic signed [15:0] raw_y_i = '0;
  logic               heading_valid_o;
  logic [15:0]        heading_o;

  // Offsets currently programmed into the block, used to aim stimulus.
  logic signed [15:0] cur_off_x = '0;
  logic signed [15:0] cur_off_y = '0;

  class heading_tracker;
    longint     bias_x;
    longint     bias_y;
    bit [15:0]  headings_due[$];
    int         mismatches;

    function new();
      bias_x     = 0;
      bias_y     = 0;
      mismatches = 0;
    endfunction

    function void set_offset(chm_cfg_e idx, logic signed [15:0] val);
      if (idx == CFG_OFFSET_X) begin
        bias_x = longint'(val);
      end else begin
        bias_y = longint'(val);
      end
    endfunction

    // Vectoring CORDIC on the corrected sample, then turns to degrees.
    function bit [15:0] heading_of(logic signed [15:0] rx, logic signed [15:0] ry);
      longint    dx;
      longint    dy;
      longint    x;
      longint    y;
      longint    xs;
      longint    ys;
      bit [31:0] z;
      bit [63:0] full;
      bit [63:0] h;
      int        steps;
      dx = longint'(rx) - bias_x;
      dy = longint'(ry) - bias_y;
      if (dx == 0 && dy == 0) begin
        return '0;
      end
      if (dx < 0) begin
        x = -dx * 256;
        y = -dy * 256;
        z = HalfTurn;
      end else begin
        x = dx * 256;
        y = dy * 256;
        z = '0;
      end
      steps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end
      end
      full = 64'd360 << ANGLE_FRAC_BITS;
      h = ({32'd0, z} * full + 64'h8000_0000) >> 32;
      if (h >= full) begin
        h = '0;
      end
      return h[15:0];
    endfunction

    function void note_sample(logic signed [15:0] rx, logic signed [15:0] ry);
      headings_due.push_back(heading_of(rx, ry));
    endfunction

    function void check_heading(logic [15:0] actual);
      bit [15:0] want;
      if (headings_due.size() == 0) begin
        $error("heading: expected none, actual %0d", actual);
        mismatches++;
      end else begin
        want = headings_due.pop_front();
        if (actual !== want) begin
          $error("heading: expected %0d, actual %0d", want, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  heading_tracker tracker = new();

  compass_heading_from_magnetometer #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .raw_x_i        (raw_x_i),
    .raw_y_i        (raw_y_i),
    .heading_valid_o(heading_valid_o),
    .heading_o      (heading_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && heading_valid_o) begin
      tracker.check_heading(heading_o);
    end
  end

  task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start   <= 1'b1;
    raw_x_i <= rx;
    raw_y_i <= ry;
    do @(posedge clk_i); while (busy);
    tracker.note_sample(rx, ry);
  endtask

  // Stop sending and let the pipeline empty out completely.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.headings_due.size() != 0) @(posedge clk_i);
    repeat (CORDIC_STEPS + 8) @(posedge clk_i);
  endtask

  task automatic write_offset(chm_cfg_e idx, logic signed [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_offset(idx, val);
    if (idx == CFG_OFFSET_X) begin
      cur_off_x = val;
    end else begin
      cur_off_y = val;
    end
  endtask

  task automatic set_offsets(logic signed [15:0] ox, logic signed [15:0] oy);
    write_offset(CFG_OFFSET_X, ox);
    write_offset(CFG_OFFSET_Y, oy);
  endtask

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic random_phase(int count, bit bursty);
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    int                 gap;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 5))
        0: begin
          // Close to the offset point, zero vector included.
          rx = cur_off_x + 16'($signed($urandom_range(0, 8)) - 4);
          ry = cur_off_y + 16'($signed($urandom_range(0, 8)) - 4);
        end
        1: begin
          rx = pick_extreme();
          ry = pick_extreme();
        end
        2: begin
          rx = cur_off_x;
          ry = 16'($urandom);
        end
        default: begin
          rx = 16'($urandom);
          ry = 16'($urandom);
        end
      endcase
      gap = bursty ? 0 : $urandom_range(0, 9);
      send_sample(rx, ry, gap);
      if ($urandom_range(0, 63) == 0) begin
        settle();
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_offsets(16'sd0, 16'sd0);

    // Axes, diagonals, the zero vector, and a tiny negative angle that
    // rounds up to a full turn and must wrap to zero.
    send_sample(16'sd0, 16'sd0, 0);
    send_sample(16'sh7fff, 16'sd0, 0);
    send_sample(16'sh8000, 16'sd0, 1);
    send_sample(16'sd0, 16'sh7fff, 0);
    send_sample(16'sd0, 16'sh8000, 2);
    send_sample(16'sh7fff, 16'sh7fff, 0);
    send_sample(16'sh8000, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh8000, 3);
    send_sample(16'sh8000, 16'sh7fff, 0);
    send_sample(16'sd1, 16'sd0, 0);
    send_sample(-16'sd1, 16'sd0, 0);
    send_sample(16'sd0, 16'sd1, 0);
    send_sample(16'sd0, -16'sd1, 0);
    send_sample(-16'sd1, -16'sd1, 0);
    send_sample(16'sh7fff, -16'sd1, 0);
    send_sample(16'sh7fff, 16'sd1, 0);
    settle();

    // Largest corrected vectors to the left, upward and up-left, and the zero vector.
    set_offsets(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 0);
    send_sample(16'sh7fff, 16'sh8000, 0);
    send_sample(16'sh8000, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh7fff, 0);
    random_phase(100, 1'b0);
    settle();

    set_offsets(16'sh8000, 16'sh7fff);
    random_phase(100, 1'b1);
    settle();

    for (int p = 0; p < 3; p++) begin
      set_offsets(16'($urandom), 16'($urandom));
      random_phase(100, p[0]);
      settle();
    end

    set_offsets(16'sd0, 16'sd0);
    random_phase(100, 1'b0);
    settle();

    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
